// ===== hw/rtl/cmt_pkg.sv =====
`default_nettype none

package cmt_pkg;

  localparam int unsigned MaxAttrs   = 8;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned OutWidth   = 32;
  localparam int unsigned AttrW      = $clog2(MaxAttrs + 1);
  localparam int unsigned AttrIdxW   = $clog2(MaxAttrs);
  localparam int unsigned HistDepth  = MaxAttrs + 1;
  localparam int unsigned HistIdxW   = $clog2(HistDepth);
  localparam int unsigned KeyW       = MaxAttrs;
  localparam int unsigned TableDepth = 1 << MaxAttrs;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned NumAttrW   = 4;
  localparam int unsigned PAddrW     = 3;
  localparam int unsigned PDataW     = 32;

  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [1:0] {
    OP_RECORD       = 2'd0,
    OP_READ_ATTR    = 2'd1,
    OP_READ_HIST    = 2'd2,
    OP_READ_PATTERN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_NO_TRACK  = 2'd2
  } status_e;

  typedef enum logic {
    REG_NUM_ATTRS = 1'b0,
    REG_TRACK     = 1'b1
  } reg_e;

  typedef struct packed {
    op_e             opcode;
    logic [KeyW-1:0] true_pattern;
    logic [KeyW-1:0] estimated_pattern;
    logic [IdxW-1:0] index;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [AttrW-1:0]    mismatch_count;
    logic [OutWidth-1:0] total_count;
    logic [OutWidth-1:0] exact_match_count;
    logic [OutWidth-1:0] selected_count;
    logic [OutWidth-1:0] selected_correct_count;
  } out_item_t;

  typedef struct packed {
    logic            en;
    logic [KeyW-1:0] key;
  } table_rd_t;

  typedef struct packed {
    count_t seen;
    count_t correct;
  } table_data_t;

  typedef struct packed {
    logic            en;
    logic [KeyW-1:0] key;
    table_data_t     data;
  } table_wr_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  // Attribute register clamped to the number of attributes the block holds.
  function automatic logic [AttrW-1:0] attr_count(input logic [NumAttrW-1:0] num);
    return (num > NumAttrW'(MaxAttrs)) ? AttrW'(MaxAttrs) : AttrW'(num);
  endfunction

  function automatic logic [KeyW-1:0] attr_mask(input logic [AttrW-1:0] n);
    logic [KeyW-1:0] m;
    for (int i = 0; i < MaxAttrs; i++) begin
      m[i] = (AttrW'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [AttrW-1:0] pop_count(input logic [KeyW-1:0] v);
    logic [AttrW-1:0] c;
    c = '0;
    for (int i = 0; i < MaxAttrs; i++) begin
      c = c + AttrW'(v[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cmt_if.sv =====
`default_nettype none

interface cmt_in_if;
  logic               valid;
  logic               ready;
  cmt_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cmt_out_if;
  logic               valid;
  logic               ready;
  cmt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/classification_match_tally.sv =====
// Channel     Dir  Handshake      Payload
// item_in     in   valid/ready    opcode, true/estimated pattern, index
// result_out  out  valid/ready    status, mismatch count, counters
// APB         in   psel/penable   num_attributes @0x0, pattern_tracking_enable @0x4
//
// One request per cycle while results drain; an accepted request is registered in
// stage 1 and its result in the result register. The pattern table read is issued
// on accept, stage 1 does the compare and counter update, same-key table writes
// are forwarded. Reset clears all counters and the table valid bits at once, no
// sweep. A stalled result holds stage 1; the input takes a request whenever
// stage 1 is empty or drains in the same cycle.
`default_nettype none

module classification_match_tally (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cmt_in_if.sink                       item_in,
  cmt_out_if.source                    result_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cmt_pkg::PAddrW-1:0]   paddr,
  input  logic [cmt_pkg::PDataW-1:0]   pwdata,
  output logic [cmt_pkg::PDataW-1:0]   prdata,
  output logic                         pready
);

  // Configuration
  logic [cmt_pkg::NumAttrW-1:0] num_attr_q;
  logic                         track_q;
  logic                         cfg_wr;
  cmt_pkg::reg_e                cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_reg = cmt_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_attr_q <= cmt_pkg::NumAttrW'(cmt_pkg::MaxAttrs);
      track_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        cmt_pkg::REG_NUM_ATTRS: num_attr_q <= pwdata[cmt_pkg::NumAttrW-1:0];
        cmt_pkg::REG_TRACK:     track_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      cmt_pkg::REG_NUM_ATTRS: prdata = cmt_pkg::PDataW'(num_attr_q);
      cmt_pkg::REG_TRACK:     prdata = cmt_pkg::PDataW'(track_q);
      default:                prdata = '0;
    endcase
  end

  logic [cmt_pkg::AttrW-1:0] n_attr;
  logic [cmt_pkg::KeyW-1:0]  mask;

  assign n_attr = cmt_pkg::attr_count(num_attr_q);
  assign mask   = cmt_pkg::attr_mask(n_attr);

  // Input stage
  logic              s1_valid_q;
  cmt_pkg::in_item_t s1_item_q;
  logic              s1_fire;
  logic              in_acc;
  logic              out_valid_q;
  cmt_pkg::out_item_t out_q;

  assign s1_fire       = s1_valid_q && (!out_valid_q || result_out.ready);
  assign item_in.ready = !s1_valid_q || s1_fire;
  assign in_acc        = item_in.valid && item_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_in.ready) begin
      s1_valid_q <= item_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= item_in.data;
    end
  end

  // Pattern table
  cmt_pkg::table_rd_t   tbl_rd;
  cmt_pkg::table_wr_t   tbl_wr;
  cmt_pkg::table_data_t tbl_data;

  assign tbl_rd.en  = in_acc;
  assign tbl_rd.key = item_in.data.true_pattern & mask;

  cmt_pattern_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (tbl_rd),
    .wr_i      (tbl_wr),
    .rd_data_o (tbl_data)
  );

  // Stage 1: compare and counter update
  cmt_pkg::count_t total_q, total_d;
  cmt_pkg::count_t exact_q, exact_d;
  cmt_pkg::count_t attr_q [cmt_pkg::MaxAttrs];
  cmt_pkg::count_t attr_d [cmt_pkg::MaxAttrs];
  cmt_pkg::count_t hist_q [cmt_pkg::HistDepth];
  cmt_pkg::count_t hist_d [cmt_pkg::HistDepth];

  logic [cmt_pkg::KeyW-1:0]  tru, est, diff;
  logic [cmt_pkg::AttrW-1:0] mism;
  logic                      exact;
  logic                      s1_is_rec;
  logic                      rec_upd;
  cmt_pkg::table_data_t      tbl_new;
  cmt_pkg::out_item_t        res;

  assign tru       = s1_item_q.true_pattern & mask;
  assign est       = s1_item_q.estimated_pattern & mask;
  assign diff      = tru ^ est;
  assign mism      = cmt_pkg::pop_count(diff);
  assign exact     = (mism == '0);
  assign s1_is_rec = (s1_item_q.opcode == cmt_pkg::OP_RECORD);
  assign rec_upd   = s1_fire && s1_is_rec;

  assign total_d = cmt_pkg::sat_inc(total_q);
  assign exact_d = exact ? cmt_pkg::sat_inc(exact_q) : exact_q;

  always_comb begin
    for (int i = 0; i < cmt_pkg::MaxAttrs; i++) begin
      attr_d[i] = (mask[i] && !diff[i]) ? cmt_pkg::sat_inc(attr_q[i]) : attr_q[i];
    end
    for (int b = 0; b < cmt_pkg::HistDepth; b++) begin
      hist_d[b] = (mism == cmt_pkg::AttrW'(b)) ? cmt_pkg::sat_inc(hist_q[b]) : hist_q[b];
    end
  end

  assign tbl_new.seen    = cmt_pkg::sat_inc(tbl_data.seen);
  assign tbl_new.correct = exact ? cmt_pkg::sat_inc(tbl_data.correct) : tbl_data.correct;

  assign tbl_wr.en   = rec_upd && track_q;
  assign tbl_wr.key  = tru;
  assign tbl_wr.data = tbl_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      exact_q <= '0;
      for (int i = 0; i < cmt_pkg::MaxAttrs; i++) begin
        attr_q[i] <= '0;
      end
      for (int b = 0; b < cmt_pkg::HistDepth; b++) begin
        hist_q[b] <= '0;
      end
    end else if (rec_upd) begin
      total_q <= total_d;
      exact_q <= exact_d;
      attr_q  <= attr_d;
      hist_q  <= hist_d;
    end
  end

  always_comb begin
    res                        = '0;
    res.status                 = cmt_pkg::ST_OK;
    res.total_count            = cmt_pkg::OutWidth'(total_q);
    res.exact_match_count      = cmt_pkg::OutWidth'(exact_q);
    case (s1_item_q.opcode)
      cmt_pkg::OP_RECORD: begin
        res.mismatch_count    = mism;
        res.total_count       = cmt_pkg::OutWidth'(total_d);
        res.exact_match_count = cmt_pkg::OutWidth'(exact_d);
        if (track_q) begin
          res.selected_count         = cmt_pkg::OutWidth'(tbl_new.seen);
          res.selected_correct_count = cmt_pkg::OutWidth'(tbl_new.correct);
        end
      end
      cmt_pkg::OP_READ_ATTR: begin
        if (s1_item_q.index < cmt_pkg::IdxW'(n_attr)) begin
          res.selected_count = cmt_pkg::OutWidth'(
            attr_q[s1_item_q.index[cmt_pkg::AttrIdxW-1:0]]);
        end else begin
          res.status = cmt_pkg::ST_BAD_INDEX;
        end
      end
      cmt_pkg::OP_READ_HIST: begin
        if (s1_item_q.index <= cmt_pkg::IdxW'(n_attr)) begin
          res.selected_count = cmt_pkg::OutWidth'(
            hist_q[s1_item_q.index[cmt_pkg::HistIdxW-1:0]]);
        end else begin
          res.status = cmt_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        if (track_q) begin
          res.selected_count         = cmt_pkg::OutWidth'(tbl_data.seen);
          res.selected_correct_count = cmt_pkg::OutWidth'(tbl_data.correct);
        end else begin
          res.status = cmt_pkg::ST_NO_TRACK;
        end
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res;
    end
  end

  assign result_out.valid = out_valid_q;
  assign result_out.data  = out_q;

  // Checks
  a_tbl_wr_on_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.en |-> (s1_fire && s1_is_rec && track_q))
    else $error("pattern table written outside a tracked record");

  a_total_only_on_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rec_upd |=> $stable(total_q))
    else $error("record count moved without a record");

  a_exact_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exact_q <= total_q)
    else $error("exact-match count above record count");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_in.ready |-> (s1_valid_q && out_valid_q && !result_out.ready))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== hw/rtl/cmt_pattern_table.sv =====
`default_nettype none

module cmt_pattern_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmt_pkg::table_rd_t   rd_i,
  input  cmt_pkg::table_wr_t   wr_i,
  output cmt_pkg::table_data_t rd_data_o
);

  cmt_pkg::count_t seen_mem [cmt_pkg::TableDepth];
  cmt_pkg::count_t corr_mem [cmt_pkg::TableDepth];

  logic [cmt_pkg::TableDepth-1:0] valid_q;
  logic                           rd_vld_q;
  cmt_pkg::table_data_t           rd_data_q;
  logic                           wr_hit;

  // A write to the key being read in the same cycle is forwarded.
  assign wr_hit = wr_i.en && (wr_i.key == rd_i.key);

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      seen_mem[wr_i.key] <= wr_i.data.seen;
      corr_mem[wr_i.key] <= wr_i.data.correct;
    end
    if (rd_i.en) begin
      if (wr_hit) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q.seen    <= seen_mem[rd_i.key];
        rd_data_q.correct <= corr_mem[rd_i.key];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.key] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= wr_hit || valid_q[rd_i.key];
      end
    end
  end

  // Entries never written read as zero.
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cmt_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SegmentItems = 135;
  localparam int unsigned HoldCycles   = 80;
  localparam logic [NumAttrW-1:0] SegAttrs [6] = '{4'd15, 4'd1, 4'd8, 4'd5, 4'd0, 4'd3};
  localparam logic SegTrack [6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

  // Tracks the counters and the pattern table and holds the responses still owed.
  class tally_checker;
    logic [NumAttrW-1:0] attr_setting;
    logic                track_en;
    count_t              total_records;
    count_t              exact_matches;
    count_t              attr_correct [MaxAttrs];
    count_t              mismatch_hist [HistDepth];
    count_t              pattern_seen [TableDepth];
    count_t              pattern_correct [TableDepth];
    out_item_t           expected_results [$];
    int unsigned         errors;

    function new();
      attr_setting  = NumAttrW'(MaxAttrs);
      track_en      = 1'b0;
      total_records = '0;
      exact_matches = '0;
      foreach (attr_correct[i]) attr_correct[i] = '0;
      foreach (mismatch_hist[i]) mismatch_hist[i] = '0;
      foreach (pattern_seen[i]) begin
        pattern_seen[i]    = '0;
        pattern_correct[i] = '0;
      end
      errors = 0;
    endfunction

    function count_t bump(count_t v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void set_reg(reg_e r, logic [PDataW-1:0] v);
      if (r == REG_NUM_ATTRS) begin
        attr_setting = v[NumAttrW-1:0];
      end else begin
        track_en = v[0];
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_request(in_item_t req);
      int unsigned     n;
      int unsigned     miss;
      logic [KeyW-1:0] tp;
      logic [KeyW-1:0] ep;
      out_item_t       r;
      n    = (attr_setting > MaxAttrs) ? MaxAttrs : attr_setting;
      miss = 0;
      r    = '0;
      // bits above the compared attributes never reach the compare or the key
      for (int i = 0; i < MaxAttrs; i++) begin
        tp[i] = req.true_pattern[i] && (i < n);
        ep[i] = req.estimated_pattern[i] && (i < n);
      end
      case (req.opcode)
        OP_RECORD: begin
          total_records = bump(total_records);
          for (int i = 0; i < n; i++) begin
            if (tp[i] != ep[i]) begin
              miss++;
            end else begin
              attr_correct[i] = bump(attr_correct[i]);
            end
          end
          if (miss == 0) exact_matches = bump(exact_matches);
          mismatch_hist[miss] = bump(mismatch_hist[miss]);
          r.mismatch_count = AttrW'(miss);
          if (track_en) begin
            pattern_seen[tp] = bump(pattern_seen[tp]);
            if (miss == 0) pattern_correct[tp] = bump(pattern_correct[tp]);
            r.selected_count         = pattern_seen[tp];
            r.selected_correct_count = pattern_correct[tp];
          end
        end
        OP_READ_ATTR: begin
          if (req.index < n) begin
            r.selected_count = attr_correct[req.index];
          end else begin
            r.status = ST_BAD_INDEX;
          end
        end
        OP_READ_HIST: begin
          if (req.index <= n) begin
            r.selected_count = mismatch_hist[req.index];
          end else begin
            r.status = ST_BAD_INDEX;
          end
        end
        default: begin
          if (track_en) begin
            r.selected_count         = pattern_seen[tp];
            r.selected_correct_count = pattern_correct[tp];
          end else begin
            r.status = ST_NO_TRACK;
          end
        end
      endcase
      r.total_count       = total_records;
      r.exact_match_count = exact_matches;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("mismatch_count", want.mismatch_count, got.mismatch_count);
      compare_field("total_count", want.total_count, got.total_count);
      compare_field("exact_match_count", want.exact_match_count, got.exact_match_count);
      compare_field("selected_count", want.selected_count, got.selected_count);
      compare_field("selected_correct_count", want.selected_correct_count,
                    got.selected_correct_count);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PAddrW-1:0]  paddr;
  logic [PDataW-1:0]  pwdata;
  logic [PDataW-1:0]  prdata;
  logic               pready;

  cmt_in_if  in_if ();
  cmt_out_if out_if ();

  classification_match_tally u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_in    (in_if),
    .result_out (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  tally_checker    tally = new();
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     cur_attrs;
  logic            hold_rx;
  logic [KeyW-1:0] key_pool [6];

  always #6 clk_i = ~clk_i;

  task automatic send_item(input op_e op, input logic [KeyW-1:0] tp, input logic [KeyW-1:0] ep,
                           input logic [IdxW-1:0] idx);
    in_item_t req;
    req.opcode            = op;
    req.true_pattern      = tp;
    req.estimated_pattern = ep;
    req.index             = idx;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tally.note_request(req);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk_i);
  endtask

  // Write with junk above the field, then read the register back.
  task automatic write_reg(input reg_e r, input logic [PDataW-1:0] v);
    logic [PDataW-1:0] field;
    field = (r == REG_NUM_ATTRS) ? PDataW'({NumAttrW{1'b1}}) : PDataW'(1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAddrW'(r) << 2;
    pwdata  <= ($urandom() & ~field) | (v & field);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    tally.set_reg(r, v);
    if (r == REG_NUM_ATTRS) cur_attrs = (v[NumAttrW-1:0] > MaxAttrs) ? MaxAttrs : v[NumAttrW-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    tally.compare_field("register readback", v & field, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_segment(input int unsigned count);
    op_e             op;
    logic [KeyW-1:0] tp;
    logic [KeyW-1:0] ep;
    logic [KeyW-1:0] low;
    logic [IdxW-1:0] idx;
    int unsigned     pick;
    low = KeyW'((1 << cur_attrs) - 1);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      op = (pick < 50) ? OP_RECORD : (pick < 65) ? OP_READ_ATTR :
           (pick < 80) ? OP_READ_HIST : OP_READ_PATTERN;
      // reuse a few keys so per-pattern counts climb; junk above the compared bits
      if ($urandom_range(99) < 60) begin
        tp = key_pool[$urandom_range(5)] ^ (KeyW'($urandom()) & ~low);
      end else begin
        tp = KeyW'($urandom());
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        ep = tp;
      end else if (pick < 60) begin
        ep = tp ^ (KeyW'($urandom()) & ~low);
      end else if (pick < 75) begin
        ep = tp ^ (KeyW'(1) << $urandom_range(KeyW - 1));
      end else begin
        ep = KeyW'($urandom());
      end
      idx = ($urandom_range(99) < 75) ? IdxW'($urandom_range(9)) : IdxW'($urandom_range(15));
      send_item(op, tp, ep, idx);
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) tally.check_result(out_if.data);
      out_if.ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    for (int c = 0; c < CycleLimit; c++) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    hold_rx     <= 1'b0;
    send_idle_pct = 23;
    recv_idle_pct = 72;
    cur_attrs     = MaxAttrs;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 6; i++) key_pool[i] = KeyW'($urandom());
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all eight attributes, tracking off
    send_item(OP_READ_PATTERN, 8'h3C, 8'h00, 4'd0);
    send_item(OP_RECORD, 8'hFF, 8'hFF, 4'd0);
    send_item(OP_RECORD, 8'h00, 8'hFF, 4'd0);
    send_item(OP_RECORD, 8'hA5, 8'h5A, 4'd15);
    send_item(OP_READ_ATTR, 8'h00, 8'h00, 4'd0);
    send_item(OP_READ_ATTR, 8'h00, 8'h00, 4'd7);
    send_item(OP_READ_ATTR, 8'h00, 8'h00, 4'd8);
    send_item(OP_READ_ATTR, 8'h00, 8'h00, 4'd15);
    send_item(OP_READ_HIST, 8'h00, 8'h00, 4'd0);
    send_item(OP_READ_HIST, 8'h00, 8'h00, 4'd8);
    send_item(OP_READ_HIST, 8'h00, 8'h00, 4'd9);
    send_item(OP_READ_HIST, 8'h00, 8'h00, 4'd15);
    drain();
    // three attributes: high bits differ but are masked, key folds to 5
    write_reg(REG_TRACK, 1);
    write_reg(REG_NUM_ATTRS, 3);
    send_item(OP_RECORD, 8'hF5, 8'h05, 4'd0);
    send_item(OP_RECORD, 8'h0D, 8'h03, 4'd0);
    send_item(OP_READ_PATTERN, 8'hFD, 8'h00, 4'd0);
    send_item(OP_READ_ATTR, 8'h00, 8'h00, 4'd2);
    send_item(OP_READ_ATTR, 8'h00, 8'h00, 4'd3);
    send_item(OP_READ_HIST, 8'h00, 8'h00, 4'd3);
    send_item(OP_READ_HIST, 8'h00, 8'h00, 4'd4);
    drain();
    // zero attributes: every record is an exact match on key 0
    write_reg(REG_NUM_ATTRS, 0);
    send_item(OP_RECORD, 8'hAA, 8'h55, 4'd0);
    send_item(OP_READ_ATTR, 8'h00, 8'h00, 4'd0);
    send_item(OP_READ_HIST, 8'h00, 8'h00, 4'd0);
    send_item(OP_READ_HIST, 8'h00, 8'h00, 4'd1);
    send_item(OP_READ_PATTERN, 8'hFF, 8'h00, 4'd0);
    drain();
    // oversized count acts as eight; table must survive tracking off and on
    write_reg(REG_NUM_ATTRS, 15);
    write_reg(REG_TRACK, 0);
    send_item(OP_RECORD, 8'hFF, 8'h00, 4'd0);
    send_item(OP_READ_PATTERN, 8'h05, 8'h00, 4'd0);
    drain();
    write_reg(REG_TRACK, 1);
    send_item(OP_READ_PATTERN, 8'h05, 8'h00, 4'd0);

    for (int s = 0; s < 6; s++) begin
      drain();
      if (s == 2) begin
        send_idle_pct = 72;
        recv_idle_pct = 23;
      end else if (s == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_NUM_ATTRS, (s == 5) ? PDataW'($urandom_range(2, 7)) : PDataW'(SegAttrs[s]));
      write_reg(REG_TRACK, PDataW'(SegTrack[s]));
      if (s == 4) begin
        // long receiver stall while requests keep coming
        fork
          begin
            hold_rx <= 1'b1;
            repeat (HoldCycles) @(posedge clk_i);
            hold_rx <= 1'b0;
          end
        join_none
      end
      random_segment(SegmentItems);
    end
    drain();
    repeat (4) @(posedge clk_i);
    if (tally.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cmt_pkg.sv
hw/rtl/cmt_if.sv
hw/rtl/cmt_pattern_table.sv
hw/rtl/classification_match_tally.sv
test/testbench.sv
